@@ rtl/core/tia_pkg.sv @@
package tia_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned ShiftW    = $clog2(DataWidth);

  // Opcodes (left OP right)
  typedef enum logic [3:0] {
    CmdAdd = 4'd0,
    CmdSub = 4'd1,
    CmdMul = 4'd2,
    CmdDiv = 4'd3,
    CmdMod = 4'd4,
    CmdOr  = 4'd5,
    CmdXor = 4'd6,
    CmdAnd = 4'd7,
    CmdShl = 4'd8,
    CmdLt  = 4'd9,
    CmdGt  = 4'd10,
    CmdEq  = 4'd11,
    CmdLe  = 4'd12,
    CmdGe  = 4'd13
  } tia_cmd_e;

  // Operand tags
  typedef enum logic [2:0] {
    TagInt    = 3'd0,
    TagObj    = 3'd1,
    TagVar    = 3'd2,
    TagLvar   = 3'd3,
    TagOther  = 3'd4
  } tia_tag_e;

  typedef struct packed {
    logic [3:0]           cmd;
    logic [DataWidth-1:0] left_value;
    logic [2:0]           left_tag;
    logic [DataWidth-1:0] right_value;
    logic [2:0]           right_tag;
  } tia_in_t;

  typedef struct packed {
    logic [DataWidth-1:0] value;
    logic [1:0]           value_tag;
    logic                 bounds_error;
    logic                 divide_by_zero;
    logic                 type_error;
  } tia_out_t;

  // Per-stage state of the divider pipeline plus the early result
  typedef struct packed {
    logic [DataWidth-1:0] rem;
    logic [DataWidth-1:0] quo;
    logic [DataWidth-1:0] dsr;
    logic                 neg_q;
    logic                 neg_r;
    logic                 sel_q;
    logic                 sel_r;
    tia_out_t             res;
  } tia_stage_t;

endpackage

@@ rtl/core/tia_div_step.sv @@
module tia_div_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                ready_i,
  input  logic                valid_i,
  input  tia_pkg::tia_stage_t stage_i,
  output logic                valid_o,
  output tia_pkg::tia_stage_t stage_o
);

  localparam int unsigned DW = tia_pkg::DataWidth;

  logic                valid_q;
  tia_pkg::tia_stage_t stage_q, stage_d;
  logic [DW:0]         shifted;
  logic [DW:0]         diff;
  logic                ge;

  // One restoring division bit
  always_comb begin
    shifted = {stage_i.rem, stage_i.quo[DW-1]};
    diff    = shifted - {1'b0, stage_i.dsr};
    ge      = shifted >= {1'b0, stage_i.dsr};
    stage_d = stage_i;
    stage_d.rem = ge ? diff[DW-1:0] : shifted[DW-1:0];
    stage_d.quo = {stage_i.quo[DW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_i && valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

@@ rtl/core/tagged_integer_alu.sv @@
// Tagged integer ALU: one transaction in, one result out, in order. The pipeline
// takes a new transaction every cycle while it is not stalled; its registers are the input
// register, the decode/multiply stage, one stage per quotient bit of the 32-step divider,
// and the output register. Empty stages close up while the output is stalled, so input
// stall rises only when every stage is full.
module tagged_integer_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tia_pkg::tia_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tia_pkg::tia_out_t out_o
);

  localparam int unsigned DW = tia_pkg::DataWidth;
  localparam int unsigned SW = tia_pkg::ShiftW;

  // Input register
  logic             in_v_q;
  tia_pkg::tia_in_t in_q;

  // Divider pipeline: index 0 is the decode stage
  logic                vd   [0:DW];
  logic                rdy_d[0:DW];
  tia_pkg::tia_stage_t sd   [0:DW];

  // Decode stage register
  logic                dec_v_q;
  tia_pkg::tia_stage_t dec_q;

  logic              out_v_q;
  tia_pkg::tia_out_t out_q, out_d;
  logic              rdy_out, rdy_in;

  // Ready chain, bubbles collapse
  assign rdy_out = !out_v_q || !out_stall_i;
  always_comb begin
    rdy_d[DW] = !vd[DW] || rdy_out;
    for (int k = DW - 1; k >= 0; k--) begin
      rdy_d[k] = !vd[k] || rdy_d[k+1];
    end
  end
  assign rdy_in     = !in_v_q || rdy_d[0];
  assign in_stall_o = !rdy_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (rdy_in) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_in && in_valid_i) begin
      in_q <= in_i;
    end
  end

  // Decode, type check, and all results other than quotient and remainder
  logic signed [DW-1:0]   a, b;
  logic [DW-1:0]          ma, mb, sum, dif;
  logic signed [2*DW-1:0] prod;
  logic                   a_neg, b_neg, lt, eq, terr;
  logic                   amin, bm1, big_l;
  tia_pkg::tia_cmd_e      cmd;
  tia_pkg::tia_stage_t    dec;

  always_comb begin
    a     = $signed(in_q.left_value);
    b     = $signed(in_q.right_value);
    cmd   = tia_pkg::tia_cmd_e'(in_q.cmd);
    a_neg = a[DW-1];
    b_neg = b[DW-1];
    ma    = a_neg ? -a : a;
    mb    = b_neg ? -b : b;
    sum   = a + b;
    dif   = a - b;
    prod  = a * b;
    lt    = a < b;
    eq    = a == b;
    amin  = a == {1'b1, {(DW-1){1'b0}}};
    bm1   = b == {DW{1'b1}};
    big_l = b[DW-1:SW] != '0;

    if (cmd inside {[tia_pkg::CmdAdd:tia_pkg::CmdShl]}) begin
      terr = (in_q.right_tag != tia_pkg::TagInt) || (in_q.left_tag > tia_pkg::TagLvar);
    end else if (cmd inside {[tia_pkg::CmdLt:tia_pkg::CmdGe]}) begin
      terr = (in_q.left_tag > tia_pkg::TagObj) || (in_q.right_tag > tia_pkg::TagObj);
    end else begin
      terr = 1'b1;
    end

    dec       = '0;
    dec.quo   = ma;
    dec.dsr   = mb;
    dec.neg_q = a_neg ^ b_neg;
    dec.neg_r = a_neg;

    if (terr) begin
      dec.res.type_error = 1'b1;
    end else begin
      if (cmd inside {[tia_pkg::CmdAdd:tia_pkg::CmdShl]}) begin
        dec.res.value_tag = in_q.left_tag[1:0];
      end
      case (cmd)
        tia_pkg::CmdAdd: begin
          dec.res.value        = sum;
          dec.res.bounds_error = ~(a[DW-1] ^ b[DW-1]) & (a[DW-1] ^ sum[DW-1]);
        end
        tia_pkg::CmdSub: begin
          dec.res.value        = dif;
          dec.res.bounds_error = (a[DW-1] ^ b[DW-1]) & (a[DW-1] ^ dif[DW-1]);
        end
        tia_pkg::CmdMul: begin
          dec.res.value        = prod[DW-1:0];
          dec.res.bounds_error = prod[2*DW-1:DW] != {DW{prod[DW-1]}};
        end
        tia_pkg::CmdDiv: begin
          if (b == '0) begin
            dec.res.divide_by_zero = 1'b1;
          end else if (amin && bm1) begin
            dec.res.value        = a;
            dec.res.bounds_error = 1'b1;
          end else begin
            dec.sel_q = 1'b1;
          end
        end
        tia_pkg::CmdMod: begin
          dec.sel_r = b != '0;
        end
        tia_pkg::CmdOr:  dec.res.value = a | b;
        tia_pkg::CmdXor: dec.res.value = a ^ b;
        tia_pkg::CmdAnd: dec.res.value = a & b;
        tia_pkg::CmdShl: begin
          if (b == '0) begin
            dec.res.value = a;
          end else if (!b_neg) begin
            dec.res.value = big_l ? '0 : a << b[SW-1:0];
          end else if (mb[DW-1:SW] != '0) begin
            dec.res.value = {DW{a_neg}};
          end else begin
            dec.res.value = a >>> mb[SW-1:0];
          end
        end
        tia_pkg::CmdLt: dec.res.value = {{(DW-1){1'b0}}, lt};
        tia_pkg::CmdGt: dec.res.value = {{(DW-1){1'b0}}, !lt && !eq};
        tia_pkg::CmdEq: dec.res.value = {{(DW-1){1'b0}}, eq};
        tia_pkg::CmdLe: dec.res.value = {{(DW-1){1'b0}}, lt || eq};
        tia_pkg::CmdGe: dec.res.value = {{(DW-1){1'b0}}, !lt};
        default: dec.res.type_error = 1'b1;
      endcase
    end
  end

  // Decode stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_v_q <= 1'b0;
    end else if (rdy_d[0]) begin
      dec_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_d[0] && in_v_q) begin
      dec_q <= dec;
    end
  end

  assign vd[0] = dec_v_q;
  assign sd[0] = dec_q;

  // Divider stages, one quotient bit each
  for (genvar k = 1; k <= DW; k++) begin : g_div
    tia_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ready_i (rdy_d[k]),
      .valid_i (vd[k-1]),
      .stage_i (sd[k-1]),
      .valid_o (vd[k]),
      .stage_o (sd[k])
    );
  end

  // Sign fix-up and result select
  always_comb begin
    out_d = sd[DW].res;
    if (sd[DW].sel_q) begin
      out_d.value = sd[DW].neg_q ? -sd[DW].quo : sd[DW].quo;
    end else if (sd[DW].sel_r) begin
      out_d.value = sd[DW].neg_r ? -sd[DW].rem : sd[DW].rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (rdy_out) begin
      out_v_q <= vd[DW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_out && vd[DW]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule

@@ tb/tagged_integer_alu_test.sv @@
module tagged_integer_alu_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tia_pkg::*;

  // Expected results in issue order; compares each result against the oldest one
  class alu_scoreboard;
    tia_out_t pending_q[$];
    int mismatches;
    int reported;

    // Bit-exact prediction of one ALU transaction
    function tia_out_t predict(tia_in_t t);
      tia_out_t r;
      logic signed [31:0] a, b;
      logic signed [63:0] wide;
      logic [31:0] ma, mb, q, m;
      bit sdiff, lt, eq;
      int cnt;
      r = '0;
      a = t.left_value;
      b = t.right_value;
      if (t.cmd <= CmdShl) begin
        if (t.right_tag != TagInt || t.left_tag > TagLvar) begin
          r.type_error = 1'b1;
        end else begin
          r.value_tag = t.left_tag[1:0];
          ma = a[31] ? -a : a;
          mb = b[31] ? -b : b;
          sdiff = a[31] != b[31];
          case (t.cmd)
            CmdAdd, CmdSub, CmdMul: begin
              if (t.cmd == CmdAdd) wide = 64'(a) + 64'(b);
              else if (t.cmd == CmdSub) wide = 64'(a) - 64'(b);
              else wide = 64'(a) * 64'(b);
              r.value = wide[31:0];
              r.bounds_error = wide != 64'(signed'(wide[31:0]));
            end
            CmdDiv: begin
              if (b == 0) begin
                r.divide_by_zero = 1'b1;
              end else if (a == 32'sh8000_0000 && b == -1) begin
                r.value = a;
                r.bounds_error = 1'b1;
              end else begin
                q = ma / mb;
                r.value = sdiff ? -q : q;
              end
            end
            CmdMod: begin
              if (b != 0) begin
                m = ma % mb;
                r.value = a[31] ? -m : m;
              end
            end
            CmdOr:  r.value = a | b;
            CmdXor: r.value = a ^ b;
            CmdAnd: r.value = a & b;
            default: begin
              if (b == 0) r.value = a;
              else if (!b[31]) r.value = (b >= 32) ? 32'd0 : a << b;
              else if (mb >= 32) r.value = {32{a[31]}};
              else begin
                cnt = mb;
                r.value = a >>> cnt;
              end
            end
          endcase
        end
      end else if (t.cmd <= CmdGe) begin
        if (t.left_tag > TagObj || t.right_tag > TagObj) begin
          r.type_error = 1'b1;
        end else begin
          lt = a < b;
          eq = a == b;
          case (t.cmd)
            CmdLt: r.value = lt;
            CmdGt: r.value = !lt && !eq;
            CmdEq: r.value = eq;
            CmdLe: r.value = lt || eq;
            default: r.value = !lt;
          endcase
        end
      end else begin
        r.type_error = 1'b1;
      end
      return r;
    endfunction

    function void note_input(tia_in_t t);
      pending_q.push_back(predict(t));
    endfunction

    function void check_result(tia_out_t got);
      tia_out_t exp_r;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (reported++ < 10) $display("ERROR: unexpected result %p", got);
        return;
      end
      exp_r = pending_q.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (reported++ < 10)
          $display("ERROR: value %h/%h tag %0d/%0d bnd %b/%b dz %b/%b terr %b/%b",
                   exp_r.value, got.value, exp_r.value_tag, got.value_tag,
                   exp_r.bounds_error, got.bounds_error, exp_r.divide_by_zero,
                   got.divide_by_zero, exp_r.type_error, got.type_error);
      end
    endfunction
  endclass

  localparam int WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  tia_in_t in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  tia_out_t out_o;

  alu_scoreboard alu_sb = new();
  int send_idle_pct;
  int recv_stall_pct;
  int idle_cycles;
  bit timed_out;

  tagged_integer_alu u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_i,
    .out_valid_o, .out_stall_i, .out_o
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Monitor: score every transaction on both sides, run the watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) alu_sb.note_input(in_i);
      if (out_valid_o && !out_stall_i) alu_sb.check_result(out_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(4)) - 32'd2;
      3: return 32'($urandom_range(80)) - 32'd40;
      4: return 32'($urandom_range(131071)) - 32'd65536;
      default: return $urandom();
    endcase
  endfunction

  // Send one transaction, holding it until accepted
  task automatic send_op(logic [3:0] cmd, logic [31:0] lv, logic [2:0] lt,
                         logic [31:0] rv, logic [2:0] rt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= '{cmd: cmd, left_value: lv, left_tag: lt, right_value: rv, right_tag: rt};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_random();
    logic [3:0] cmd;
    logic [2:0] lt, rt;
    cmd = ($urandom_range(49) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(13));
    if ($urandom_range(9) < 8) begin
      lt = (cmd <= CmdShl) ? 3'($urandom_range(3)) : 3'($urandom_range(1));
      rt = (cmd <= CmdShl) ? TagInt : 3'($urandom_range(1));
    end else begin
      lt = 3'($urandom_range(7));
      rt = 3'($urandom_range(7));
    end
    send_op(cmd, rand_value(), lt, rand_value(), rt);
  endtask

  initial begin
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every opcode, special cases
    send_op(CmdAdd, 32'h7fff_ffff, TagInt, 32'd1, TagInt);
    send_op(CmdSub, 32'h8000_0000, TagVar, 32'd1, TagInt);
    send_op(CmdMul, 32'h8000_0000, TagLvar, 32'hffff_ffff, TagInt);
    send_op(CmdMul, 32'h0001_0000, TagObj, 32'hffff_8000, TagInt);
    send_op(CmdDiv, 32'h8000_0000, TagInt, 32'hffff_ffff, TagInt);
    send_op(CmdDiv, 32'd7, TagInt, 32'd0, TagInt);
    send_op(CmdDiv, 32'hffff_fff9, TagInt, 32'd2, TagInt);
    send_op(CmdMod, 32'd7, TagInt, 32'd0, TagInt);
    send_op(CmdMod, 32'h8000_0000, TagInt, 32'hffff_ffff, TagInt);
    send_op(CmdMod, 32'hffff_fff9, TagInt, 32'd2, TagInt);
    send_op(CmdOr, 32'hf0f0_f0f0, TagInt, 32'h0f0f_0f0f, TagInt);
    send_op(CmdXor, 32'hffff_ffff, TagInt, 32'h1234_5678, TagInt);
    send_op(CmdAnd, 32'hffff_ffff, TagInt, 32'h8000_0001, TagInt);
    send_op(CmdShl, 32'h8765_4321, TagInt, 32'd32, TagInt);
    send_op(CmdShl, 32'h8765_4321, TagInt, 32'hffff_ffe0, TagInt);
    send_op(CmdShl, 32'h8765_4321, TagInt, 32'hffff_fffc, TagInt);
    send_op(CmdShl, 32'h8765_4321, TagInt, 32'd0, TagInt);
    send_op(CmdShl, 32'h8765_4321, TagInt, 32'h8000_0000, TagInt);
    send_op(CmdLt, 32'h8000_0000, TagObj, 32'h7fff_ffff, TagInt);
    send_op(CmdGt, 32'd5, TagInt, 32'd5, TagObj);
    send_op(CmdEq, 32'd5, TagInt, 32'd5, TagInt);
    send_op(CmdLe, 32'd5, TagInt, 32'd5, TagInt);
    send_op(CmdGe, 32'hffff_ffff, TagInt, 32'd0, TagInt);
    send_op(CmdAdd, 32'd1, TagOther, 32'd1, TagInt);
    send_op(CmdEq, 32'd1, TagVar, 32'd1, 3'd7);
    send_op(4'd15, 32'd1, TagInt, 32'd1, TagInt);

    // Random, across idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 65; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 65; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      repeat (450) send_random();
    end
    in_valid_i <= 1'b0;

    while (alu_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (alu_sb.mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
